### hdl/ycsa_pkg.sv
package ycsa_pkg;

    // Field widths
    localparam int SIZE_W   = 13;
    localparam int ORIG_W   = 12;
    localparam int COORD_W  = 12;
    localparam int OFF_W    = 25;
    localparam int IDX_W    = 3;

    // Divider geometry: quotient never exceeds a crop size
    localparam int QUO_W    = SIZE_W;
    localparam int PROD_W   = COORD_W + SIZE_W;
    localparam int POS_W    = SIZE_W + 1;
    localparam int LANES    = 2;
    localparam int LANE_X   = 0;
    localparam int LANE_Y   = 1;

    localparam int MAX_DIM_DEFAULT = 4096;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_CROP_LEFT     = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_CROP_TOP      = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_CROP_WIDTH    = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_CROP_HEIGHT   = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_TARGET_WIDTH  = IDX_W'(6);
    localparam logic [IDX_W-1:0] REG_TARGET_HEIGHT = IDX_W'(7);

    // Register reset values
    localparam logic [SIZE_W-1:0] RST_SOURCE_WIDTH  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] RST_SOURCE_HEIGHT = SIZE_W'(640);
    localparam logic [ORIG_W-1:0] RST_CROP_LEFT     = ORIG_W'(0);
    localparam logic [ORIG_W-1:0] RST_CROP_TOP      = ORIG_W'(0);
    localparam logic [SIZE_W-1:0] RST_CROP_WIDTH    = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] RST_CROP_HEIGHT   = SIZE_W'(128);
    localparam logic [SIZE_W-1:0] RST_TARGET_WIDTH  = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] RST_TARGET_HEIGHT = SIZE_W'(128);

    // Per-item data that rides along the divider
    typedef struct packed {
        logic               mode;
        logic               in_plane;
        logic [PROD_W-1:0]  dmul;
        logic [COORD_W-1:0] col;
    } div_side_t;

    // Clamp a size register to the largest supported dimension
    function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] v, input int max_dim);
        logic [SIZE_W-1:0] res;
        res = v;
        if (int'(v) > max_dim)
        begin
            res = SIZE_W'(max_dim);
        end
        return res;
    endfunction

    // Clamp a crop origin to the last supported position
    function automatic logic [ORIG_W-1:0] sat_origin(input logic [ORIG_W-1:0] v,
                                                     input int max_dim);
        logic [ORIG_W-1:0] res;
        res = v;
        if (int'(v) > max_dim - 1)
        begin
            res = ORIG_W'(max_dim - 1);
        end
        return res;
    endfunction

endpackage

### hdl/ycsa_div.sv
// Pipelined restoring divider, two lanes, one quotient bit per stage.
// The dividend must stay below den * 2**QUO_W for a meaningful quotient.
module ycsa_div (
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  logic                                                    in_valid,
    output logic                                                    in_ready,
    input  logic [ycsa_pkg::LANES-1:0][ycsa_pkg::PROD_W-1:0]        num,
    input  logic [ycsa_pkg::LANES-1:0][ycsa_pkg::SIZE_W-1:0]        den,
    input  ycsa_pkg::div_side_t                                     in_side,
    output logic                                                    out_valid,
    input  logic                                                    out_ready,
    output logic [ycsa_pkg::LANES-1:0][ycsa_pkg::QUO_W-1:0]         quo,
    output ycsa_pkg::div_side_t                                     out_side
);

    localparam int STAGES = ycsa_pkg::QUO_W;
    localparam int SW     = ycsa_pkg::SIZE_W;
    localparam int QW     = ycsa_pkg::QUO_W;
    localparam int NL     = ycsa_pkg::LANES;

    logic                      v_reg    [STAGES];
    logic [STAGES:0]           go;
    logic [NL-1:0][SW-1:0]     rem_reg  [STAGES];
    logic [NL-1:0][QW-1:0]     lo_reg   [STAGES];
    logic [NL-1:0][QW-1:0]     quo_reg  [STAGES];
    logic [NL-1:0][SW-1:0]     den_reg  [STAGES];
    ycsa_pkg::div_side_t       side_reg [STAGES];

    logic                      v_in     [STAGES];
    logic [NL-1:0][SW-1:0]     rem_in   [STAGES];
    logic [NL-1:0][QW-1:0]     lo_in    [STAGES];
    logic [NL-1:0][QW-1:0]     quo_in   [STAGES];
    logic [NL-1:0][SW-1:0]     den_in   [STAGES];
    ycsa_pkg::div_side_t       side_in  [STAGES];

    logic [NL-1:0][SW-1:0]     rem_nx   [STAGES];
    logic [NL-1:0][QW-1:0]     lo_nx    [STAGES];
    logic [NL-1:0][QW-1:0]     quo_nx   [STAGES];

    // A stage loads when it is empty or its item moves on
    assign go[STAGES] = out_ready;

    genvar s, l;
    generate
        for (s = 0; s < STAGES; s++)
        begin : g_stage
            assign go[s] = !v_reg[s] || go[s+1];

            // Stage source: input port or previous stage
            if (s == 0)
            begin : g_first
                assign v_in[s]    = in_valid;
                assign den_in[s]  = den;
                assign side_in[s] = in_side;
                assign quo_in[s]  = '0;
                for (l = 0; l < NL; l++)
                begin : g_load
                    assign rem_in[s][l] = SW'(num[l][ycsa_pkg::PROD_W-1:QW]);
                    assign lo_in[s][l]  = num[l][QW-1:0];
                end
            end
            else
            begin : g_next
                assign v_in[s]    = v_reg[s-1];
                assign den_in[s]  = den_reg[s-1];
                assign side_in[s] = side_reg[s-1];
                assign quo_in[s]  = quo_reg[s-1];
                assign rem_in[s]  = rem_reg[s-1];
                assign lo_in[s]   = lo_reg[s-1];
            end

            // One trial subtraction per lane
            for (l = 0; l < NL; l++)
            begin : g_lane
                logic [SW:0] trial;
                logic [SW:0] diff;
                logic        ge;

                assign trial          = {rem_in[s][l], lo_in[s][l][QW-1]};
                assign diff           = trial - {1'b0, den_in[s][l]};
                assign ge             = trial >= {1'b0, den_in[s][l]};
                assign rem_nx[s][l]   = ge ? diff[SW-1:0] : trial[SW-1:0];
                assign lo_nx[s][l]    = {lo_in[s][l][QW-2:0], 1'b0};
                assign quo_nx[s][l]   = {quo_in[s][l][QW-2:0], ge};
            end

            // Advance valid bit
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[s] <= 1'b0;
                end
                else if (go[s])
                begin
                    v_reg[s] <= v_in[s];
                end
            end

            // Advance payload
            always_ff @(posedge clk)
            begin
                if (go[s])
                begin
                    rem_reg[s]  <= rem_nx[s];
                    lo_reg[s]   <= lo_nx[s];
                    quo_reg[s]  <= quo_nx[s];
                    den_reg[s]  <= den_in[s];
                    side_reg[s] <= side_in[s];
                end
            end
        end
    endgenerate

    assign in_ready  = go[0];
    assign out_valid = v_reg[STAGES-1];
    assign quo       = quo_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

### hdl/yuv420sp_crop_scale_address_top.sv
// Pipeline: 19 register stages (2 setup, 13 divider, 4 offset); the first loads at
// the accept edge. Empty stages fill while the output is stalled.
// Throughput: one item per cycle while out_ready is high; the 13-stage quotient
// divider, one bit per stage, sets the depth.
// Reset: configuration registers return to their defaults, all valid bits clear.
module yuv420sp_crop_scale_address_top #(
    parameter int MAX_DIM = ycsa_pkg::MAX_DIM_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ycsa_pkg::IDX_W-1:0]    cfg_index,
    input  logic [ycsa_pkg::SIZE_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ycsa_pkg::COORD_W-1:0]  out_col,
    input  logic [ycsa_pkg::COORD_W-1:0]  out_row,
    input  logic                          mode,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ycsa_pkg::OFF_W-1:0]    source_offset,
    output logic [ycsa_pkg::OFF_W-1:0]    dest_offset,
    output logic                          in_range
);

    localparam int SW      = ycsa_pkg::SIZE_W;
    localparam int OW      = ycsa_pkg::ORIG_W;
    localparam int CW      = ycsa_pkg::COORD_W;
    localparam int FW      = ycsa_pkg::OFF_W;
    localparam int PW      = ycsa_pkg::PROD_W;
    localparam int XW      = ycsa_pkg::POS_W;
    localparam int SPROD_W = ycsa_pkg::POS_W + ycsa_pkg::SIZE_W;
    localparam int PLANE_W = 2 * ycsa_pkg::SIZE_W;
    localparam int LX      = ycsa_pkg::LANE_X;
    localparam int LY      = ycsa_pkg::LANE_Y;

    // Halve a size or origin for the chroma plane
    function automatic logic [SW-1:0] pick_half(input logic [SW-1:0] v, input logic half);
        return half ? (v >> 1) : v;
    endfunction

    // Configuration registers
    logic [SW-1:0] source_width_reg;
    logic [SW-1:0] source_height_reg;
    logic [OW-1:0] crop_left_reg;
    logic [OW-1:0] crop_top_reg;
    logic [SW-1:0] crop_width_reg;
    logic [SW-1:0] crop_height_reg;
    logic [SW-1:0] target_width_reg;
    logic [SW-1:0] target_height_reg;

    logic [FW-1:0]      plane_src_reg;
    logic [FW-1:0]      plane_dst_reg;
    logic [PLANE_W-1:0] plane_src_next;
    logic [PLANE_W-1:0] plane_dst_next;

    // Stall chain
    logic go_a, go_b, go_c, go_d, go_e, go_f;

    // Stage A: coordinate capture and range check
    logic          a_v_reg;
    logic [CW-1:0] a_col_reg;
    logic [CW-1:0] a_row_reg;
    logic          a_mode_reg;
    logic          a_inside_reg;
    logic [SW-1:0] tw_a;
    logic [SW-1:0] th_a;
    logic          inside_next;

    // Stage B: scaled dividends and destination row product
    logic                   b_v_reg;
    logic [1:0][PW-1:0]     b_num_reg;
    logic [PW-1:0]          b_dmul_reg;
    logic [CW-1:0]          b_col_reg;
    logic                   b_mode_reg;
    logic                   b_inside_reg;
    logic [SW-1:0]          cw_b;
    logic [SW-1:0]          ch_b;
    logic [SW-1:0]          tw_b;
    logic [1:0][PW-1:0]     num_next;
    logic [PW-1:0]          dmul_next;

    // Divider boundary
    logic                               div_in_ready;
    logic [1:0][SW-1:0]                 div_den;
    ycsa_pkg::div_side_t                div_in_side;
    logic                               div_out_valid;
    logic                               div_out_ready;
    logic [1:0][ycsa_pkg::QUO_W-1:0]    div_quo;
    ycsa_pkg::div_side_t                div_out_side;

    // Stage C: source position and linear destination index
    logic          c_v_reg;
    logic [XW-1:0] c_sx_reg;
    logic [XW-1:0] c_sy_reg;
    logic [FW-1:0] c_dlin_reg;
    logic          c_mode_reg;
    logic          c_inside_reg;
    logic [SW-1:0] cl_c;
    logic [SW-1:0] ct_c;

    // Stage D: source row product and destination offset
    logic               d_v_reg;
    logic [FW-1:0]      d_prod_reg;
    logic [XW-1:0]      d_sx_reg;
    logic [FW-1:0]      d_dst_reg;
    logic               d_mode_reg;
    logic               d_inside_reg;
    logic [SW-1:0]      sw_d;
    logic [SPROD_W-1:0] sprod_d;
    logic [FW-1:0]      dst_next;

    // Stage E: linear source index
    logic          e_v_reg;
    logic [FW-1:0] e_slin_reg;
    logic [FW-1:0] e_dst_reg;
    logic          e_mode_reg;
    logic          e_inside_reg;

    // Stage F: output register
    logic          f_v_reg;
    logic [FW-1:0] f_src_reg;
    logic [FW-1:0] f_dst_reg;
    logic          f_inside_reg;
    logic [FW-1:0] src_next;

    // Write configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= ycsa_pkg::sat_size(ycsa_pkg::RST_SOURCE_WIDTH, MAX_DIM);
            source_height_reg <= ycsa_pkg::sat_size(ycsa_pkg::RST_SOURCE_HEIGHT, MAX_DIM);
            crop_left_reg     <= ycsa_pkg::sat_origin(ycsa_pkg::RST_CROP_LEFT, MAX_DIM);
            crop_top_reg      <= ycsa_pkg::sat_origin(ycsa_pkg::RST_CROP_TOP, MAX_DIM);
            crop_width_reg    <= ycsa_pkg::sat_size(ycsa_pkg::RST_CROP_WIDTH, MAX_DIM);
            crop_height_reg   <= ycsa_pkg::sat_size(ycsa_pkg::RST_CROP_HEIGHT, MAX_DIM);
            target_width_reg  <= ycsa_pkg::sat_size(ycsa_pkg::RST_TARGET_WIDTH, MAX_DIM);
            target_height_reg <= ycsa_pkg::sat_size(ycsa_pkg::RST_TARGET_HEIGHT, MAX_DIM);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                ycsa_pkg::REG_SOURCE_WIDTH:
                    source_width_reg  <= ycsa_pkg::sat_size(cfg_data, MAX_DIM);
                ycsa_pkg::REG_SOURCE_HEIGHT:
                    source_height_reg <= ycsa_pkg::sat_size(cfg_data, MAX_DIM);
                ycsa_pkg::REG_CROP_LEFT:
                    crop_left_reg     <= ycsa_pkg::sat_origin(cfg_data[OW-1:0], MAX_DIM);
                ycsa_pkg::REG_CROP_TOP:
                    crop_top_reg      <= ycsa_pkg::sat_origin(cfg_data[OW-1:0], MAX_DIM);
                ycsa_pkg::REG_CROP_WIDTH:
                    crop_width_reg    <= ycsa_pkg::sat_size(cfg_data, MAX_DIM);
                ycsa_pkg::REG_CROP_HEIGHT:
                    crop_height_reg   <= ycsa_pkg::sat_size(cfg_data, MAX_DIM);
                ycsa_pkg::REG_TARGET_WIDTH:
                    target_width_reg  <= ycsa_pkg::sat_size(cfg_data, MAX_DIM);
                ycsa_pkg::REG_TARGET_HEIGHT:
                    target_height_reg <= ycsa_pkg::sat_size(cfg_data, MAX_DIM);
                default:
                    ;
            endcase
        end
    end

    // Track luma plane sizes, the base of the chroma planes
    assign plane_src_next = PLANE_W'(source_width_reg) * PLANE_W'(source_height_reg);
    assign plane_dst_next = PLANE_W'(target_width_reg) * PLANE_W'(target_height_reg);

    always_ff @(posedge clk)
    begin
        plane_src_reg <= plane_src_next[FW-1:0];
        plane_dst_reg <= plane_dst_next[FW-1:0];
    end

    // Stall chain: a stage loads when empty or when its item moves on
    assign go_f          = !f_v_reg || out_ready;
    assign go_e          = !e_v_reg || go_f;
    assign go_d          = !d_v_reg || go_e;
    assign go_c          = !c_v_reg || go_d;
    assign div_out_ready = go_c;
    assign go_b          = !b_v_reg || div_in_ready;
    assign go_a          = !a_v_reg || go_b;
    assign in_ready      = go_a;

    // Stage A: check the coordinate against the selected plane
    assign tw_a        = pick_half(target_width_reg, mode);
    assign th_a        = pick_half(target_height_reg, mode);
    assign inside_next = (SW'(out_col) < tw_a) && (SW'(out_row) < th_a);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else if (go_a)
        begin
            a_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go_a)
        begin
            a_col_reg    <= out_col;
            a_row_reg    <= out_row;
            a_mode_reg   <= mode;
            a_inside_reg <= inside_next;
        end
    end

    // Stage B: scale coordinates by the crop size
    assign cw_b          = pick_half(crop_width_reg, a_mode_reg);
    assign ch_b          = pick_half(crop_height_reg, a_mode_reg);
    assign tw_b          = pick_half(target_width_reg, a_mode_reg);
    assign num_next[LX]  = PW'(a_col_reg) * PW'(cw_b);
    assign num_next[LY]  = PW'(a_row_reg) * PW'(ch_b);
    assign dmul_next     = PW'(a_row_reg) * PW'(tw_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_v_reg <= 1'b0;
        end
        else if (go_b)
        begin
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go_b)
        begin
            b_num_reg    <= num_next;
            b_dmul_reg   <= dmul_next;
            b_col_reg    <= a_col_reg;
            b_mode_reg   <= a_mode_reg;
            b_inside_reg <= a_inside_reg;
        end
    end

    // Divide by the target size of the selected plane
    assign div_den[LX]          = pick_half(target_width_reg, b_mode_reg);
    assign div_den[LY]          = pick_half(target_height_reg, b_mode_reg);
    assign div_in_side.mode     = b_mode_reg;
    assign div_in_side.in_plane = b_inside_reg;
    assign div_in_side.dmul     = b_dmul_reg;
    assign div_in_side.col      = b_col_reg;

    ycsa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_v_reg),
        .in_ready  (div_in_ready),
        .num       (b_num_reg),
        .den       (div_den),
        .in_side   (div_in_side),
        .out_valid (div_out_valid),
        .out_ready (div_out_ready),
        .quo       (div_quo),
        .out_side  (div_out_side)
    );

    // Stage C: add crop origin, finish destination index
    assign cl_c = pick_half(SW'(crop_left_reg), div_out_side.mode);
    assign ct_c = pick_half(SW'(crop_top_reg), div_out_side.mode);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_v_reg <= 1'b0;
        end
        else if (go_c)
        begin
            c_v_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go_c)
        begin
            c_sx_reg     <= XW'(cl_c) + XW'(div_quo[LX]);
            c_sy_reg     <= XW'(ct_c) + XW'(div_quo[LY]);
            c_dlin_reg   <= FW'(div_out_side.dmul) + FW'(div_out_side.col);
            c_mode_reg   <= div_out_side.mode;
            c_inside_reg <= div_out_side.in_plane;
        end
    end

    // Stage D: source row times line pitch, destination byte offset
    assign sw_d     = pick_half(source_width_reg, c_mode_reg);
    assign sprod_d  = SPROD_W'(c_sy_reg) * SPROD_W'(sw_d);
    assign dst_next = c_mode_reg ? (plane_dst_reg + (c_dlin_reg << 1)) : c_dlin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
        end
        else if (go_d)
        begin
            d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go_d)
        begin
            d_prod_reg   <= sprod_d[FW-1:0];
            d_sx_reg     <= c_sx_reg;
            d_dst_reg    <= dst_next;
            d_mode_reg   <= c_mode_reg;
            d_inside_reg <= c_inside_reg;
        end
    end

    // Stage E: linear source index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg <= 1'b0;
        end
        else if (go_e)
        begin
            e_v_reg <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go_e)
        begin
            e_slin_reg   <= d_prod_reg + FW'(d_sx_reg);
            e_dst_reg    <= d_dst_reg;
            e_mode_reg   <= d_mode_reg;
            e_inside_reg <= d_inside_reg;
        end
    end

    // Stage F: source byte offset, drop offsets of out-of-range items
    assign src_next = e_mode_reg ? (plane_src_reg + (e_slin_reg << 1)) : e_slin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else if (go_f)
        begin
            f_v_reg <= e_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go_f)
        begin
            f_src_reg    <= e_inside_reg ? src_next : '0;
            f_dst_reg    <= e_inside_reg ? e_dst_reg : '0;
            f_inside_reg <= e_inside_reg;
        end
    end

    assign out_valid     = f_v_reg;
    assign source_offset = f_src_reg;
    assign dest_offset   = f_dst_reg;
    assign in_range      = f_inside_reg;

    // An out-of-range item carries zero offsets
    a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |-> source_offset == '0 && dest_offset == '0)
        else $error("out-of-range item with nonzero offset");

    // A stalled divider result holds until stage C takes it
    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        div_out_valid && !div_out_ready |=> div_out_valid && $stable(div_quo))
        else $error("divider result lost while stalled");

    // A stalled stage A item stays put
    a_stage_a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        a_v_reg && !go_b |=> a_v_reg && $stable(a_col_reg) && $stable(a_row_reg))
        else $error("stage A item lost while stalled");

endmodule

### dv/tb_yuv420sp_crop_scale_address_top.sv
module tb_yuv420sp_crop_scale_address_top;

    localparam int MAX_DIM     = ycsa_pkg::MAX_DIM_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 25;
    localparam int PHASE_ITEMS = 130;
    localparam int SW          = ycsa_pkg::SIZE_W;
    localparam int CW          = ycsa_pkg::COORD_W;
    localparam int FW          = ycsa_pkg::OFF_W;
    localparam int IW          = ycsa_pkg::IDX_W;
    localparam int OW          = ycsa_pkg::ORIG_W;

    localparam logic MODE_LUMA   = 1'b0;
    localparam logic MODE_CHROMA = 1'b1;

    typedef struct packed {
        logic [FW-1:0] source_offset;
        logic [FW-1:0] dest_offset;
        logic          in_range;
    } offsets_t;

    // Holds a copy of the crop/scale registers and the offsets still owed
    class crop_scale_offsets;
        longint unsigned src_width;
        longint unsigned src_height;
        longint unsigned crop_left;
        longint unsigned crop_top;
        longint unsigned crop_width;
        longint unsigned crop_height;
        longint unsigned tgt_width;
        longint unsigned tgt_height;
        offsets_t        owed[$];
        int              mismatches;

        function new();
            src_width   = 64'(ycsa_pkg::RST_SOURCE_WIDTH);
            src_height  = 64'(ycsa_pkg::RST_SOURCE_HEIGHT);
            crop_left   = 64'(ycsa_pkg::RST_CROP_LEFT);
            crop_top    = 64'(ycsa_pkg::RST_CROP_TOP);
            crop_width  = 64'(ycsa_pkg::RST_CROP_WIDTH);
            crop_height = 64'(ycsa_pkg::RST_CROP_HEIGHT);
            tgt_width   = 64'(ycsa_pkg::RST_TARGET_WIDTH);
            tgt_height  = 64'(ycsa_pkg::RST_TARGET_HEIGHT);
            mismatches  = 0;
        endfunction

        // Clamp sizes to MAX_DIM; origins keep their low bits and clamp to MAX_DIM-1
        function void write_reg(logic [IW-1:0] idx, logic [SW-1:0] data);
            longint unsigned sz;
            longint unsigned org;
            sz  = 64'(data);
            org = 64'(data[OW-1:0]);
            if (sz > MAX_DIM)
            begin
                sz = 64'(MAX_DIM);
            end
            if (org > MAX_DIM - 1)
            begin
                org = 64'(MAX_DIM - 1);
            end
            case (idx)
                ycsa_pkg::REG_SOURCE_WIDTH:  src_width   = sz;
                ycsa_pkg::REG_SOURCE_HEIGHT: src_height  = sz;
                ycsa_pkg::REG_CROP_LEFT:     crop_left   = org;
                ycsa_pkg::REG_CROP_TOP:      crop_top    = org;
                ycsa_pkg::REG_CROP_WIDTH:    crop_width  = sz;
                ycsa_pkg::REG_CROP_HEIGHT:   crop_height = sz;
                ycsa_pkg::REG_TARGET_WIDTH:  tgt_width   = sz;
                ycsa_pkg::REG_TARGET_HEIGHT: tgt_height  = sz;
                default: ;
            endcase
        endfunction

        // Truncating divide, zero divisor gives zero
        function longint unsigned quot(longint unsigned num, longint unsigned den);
            return (den == 0) ? 0 : num / den;
        endfunction

        // Nearest-neighbor source and destination offsets for one element
        function offsets_t scaled_offsets(logic [CW-1:0] col, logic [CW-1:0] row,
                                          logic md);
            longint unsigned c, r, tw, th, cx, cy, cw, ch, sx, sy, src, dst;
            offsets_t        res;
            res = '0;
            c   = 64'(col);
            r   = 64'(row);
            if (md == MODE_LUMA)
            begin
                tw = tgt_width;
                th = tgt_height;
                cx = crop_left;
                cy = crop_top;
                cw = crop_width;
                ch = crop_height;
            end
            else
            begin
                // chroma plane: halve the target and crop sizes and the crop origin
                tw = tgt_width >> 1;
                th = tgt_height >> 1;
                cx = crop_left >> 1;
                cy = crop_top >> 1;
                cw = crop_width >> 1;
                ch = crop_height >> 1;
            end
            if (c < tw && r < th)
            begin
                sx = cx + quot(c * cw, tw);
                sy = cy + quot(r * ch, th);
                if (md == MODE_LUMA)
                begin
                    src = sy * src_width + sx;
                    dst = r * tw + c;
                end
                else
                begin
                    src = src_width * src_height + 2 * (sy * (src_width >> 1) + sx);
                    dst = tgt_width * tgt_height + 2 * (r * tw + c);
                end
                res.source_offset = src[FW-1:0];
                res.dest_offset   = dst[FW-1:0];
                res.in_range      = 1'b1;
            end
            return res;
        endfunction

        function void note_coord(logic [CW-1:0] col, logic [CW-1:0] row, logic md);
            owed.push_back(scaled_offsets(col, row, md));
        endfunction

        function void check_offsets(offsets_t got);
            offsets_t exp_r;
            if (owed.size() == 0)
            begin
                $error("result with no item pending: source_offset %0d dest_offset %0d in_range %0d",
                       got.source_offset, got.dest_offset, got.in_range);
                mismatches++;
                return;
            end
            exp_r = owed.pop_front();
            if (got.source_offset !== exp_r.source_offset)
            begin
                $error("source_offset mismatch: expected %0d, actual %0d",
                       exp_r.source_offset, got.source_offset);
                mismatches++;
            end
            if (got.dest_offset !== exp_r.dest_offset)
            begin
                $error("dest_offset mismatch: expected %0d, actual %0d",
                       exp_r.dest_offset, got.dest_offset);
                mismatches++;
            end
            if (got.in_range !== exp_r.in_range)
            begin
                $error("in_range mismatch: expected %0d, actual %0d",
                       exp_r.in_range, got.in_range);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [IW-1:0]        cfg_index;
    logic [SW-1:0]        cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [CW-1:0]        out_col;
    logic [CW-1:0]        out_row;
    logic                 mode;
    logic                 out_valid;
    logic                 out_ready;
    logic [FW-1:0]        source_offset;
    logic [FW-1:0]        dest_offset;
    logic                 in_range;

    crop_scale_offsets    offsets_sb = new();
    int                   src_idle_pct  = 0;
    int                   sink_idle_pct = 0;
    int                   cycle_count   = 0;

    yuv420sp_crop_scale_address_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .out_col       (out_col),
        .out_row       (out_row),
        .mode          (mode),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .source_offset (source_offset),
        .dest_offset   (dest_offset),
        .in_range      (in_range)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Track register writes, accepted items and returned results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                offsets_sb.write_reg(cfg_index, cfg_data);
            end
            if (in_valid && in_ready)
            begin
                offsets_sb.note_coord(out_col, out_row, mode);
            end
            if (out_valid && out_ready)
            begin
                offsets_sb.check_offsets({source_offset, dest_offset, in_range});
            end
        end
    end

    // Stall the result side in short random bursts
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && $urandom_range(1, 100) <= sink_idle_pct)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Hold one register write until taken; the caller lowers cfg_valid
    task automatic put_reg(input logic [IW-1:0] idx, input logic [SW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic apply_config(input logic [SW-1:0] sw, input logic [SW-1:0] sh,
                                input logic [SW-1:0] cx, input logic [SW-1:0] cy,
                                input logic [SW-1:0] cw, input logic [SW-1:0] ch,
                                input logic [SW-1:0] tw, input logic [SW-1:0] th);
        put_reg(ycsa_pkg::REG_SOURCE_WIDTH, sw);
        put_reg(ycsa_pkg::REG_SOURCE_HEIGHT, sh);
        put_reg(ycsa_pkg::REG_CROP_LEFT, cx);
        put_reg(ycsa_pkg::REG_CROP_TOP, cy);
        put_reg(ycsa_pkg::REG_CROP_WIDTH, cw);
        put_reg(ycsa_pkg::REG_CROP_HEIGHT, ch);
        put_reg(ycsa_pkg::REG_TARGET_WIDTH, tw);
        put_reg(ycsa_pkg::REG_TARGET_HEIGHT, th);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every owed result, then wait out DRAIN_WAIT;
    // the first edge lets the monitor note an item accepted at the last edge
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (offsets_sb.owed.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Present one item, hold it until accepted, then maybe idle
    task automatic send_item(input logic [CW-1:0] col, input logic [CW-1:0] row,
                             input logic md);
        in_valid <= 1'b1;
        out_col  <= col;
        out_row  <= row;
        mode     <= md;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if ($urandom_range(1, 100) <= src_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Mostly in-plane coordinates, the rest anywhere in the field range
    task automatic run_random(input int n, input int pause_at);
        logic [CW-1:0]      col;
        logic [CW-1:0]      row;
        logic               md;
        longint unsigned    lw;
        longint unsigned    lh;
        for (int i = 0; i < n; i++)
        begin
            if (pause_at > 0 && i == pause_at)
            begin
                wait_drained();
            end
            md = 1'($urandom_range(0, 1));
            lw = (md == MODE_CHROMA) ? offsets_sb.tgt_width >> 1 : offsets_sb.tgt_width;
            lh = (md == MODE_CHROMA) ? offsets_sb.tgt_height >> 1 : offsets_sb.tgt_height;
            if (lw == 0 || lh == 0 || $urandom_range(0, 3) == 0)
            begin
                col = CW'($urandom);
                row = CW'($urandom);
            end
            else
            begin
                col = CW'($urandom_range(0, int'(lw - 1)));
                row = CW'($urandom_range(0, int'(lh - 1)));
            end
            send_item(col, row, md);
        end
    endtask

    initial
    begin
        logic [SW-1:0] sw, sh, cx, cy, cw, ch, tw, th;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        out_col   = '0;
        out_row   = '0;
        mode      = MODE_LUMA;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: plane edges, field extremes, alternating bit patterns
        src_idle_pct  = 25;
        sink_idle_pct = 25;
        send_item(12'd0, 12'd0, MODE_LUMA);
        send_item(12'd63, 12'd127, MODE_LUMA);
        send_item(12'd64, 12'd0, MODE_LUMA);
        send_item(12'd0, 12'd128, MODE_LUMA);
        send_item(12'd63, 12'd0, MODE_LUMA);
        send_item(12'd0, 12'd127, MODE_LUMA);
        send_item(12'd4095, 12'd4095, MODE_LUMA);
        send_item(12'hAAA, 12'h555, MODE_LUMA);
        send_item(12'd0, 12'd0, MODE_CHROMA);
        send_item(12'd31, 12'd63, MODE_CHROMA);
        send_item(12'd32, 12'd0, MODE_CHROMA);
        send_item(12'd0, 12'd64, MODE_CHROMA);
        send_item(12'd4095, 12'd4095, MODE_CHROMA);
        send_item(12'h555, 12'hAAA, MODE_CHROMA);

        // Oversized registers saturate, offsets wrap
        wait_drained();
        apply_config(13'd8191, 13'd4097, 13'd8191, 13'd4095,
                     13'd4096, 13'd8191, 13'd4096, 13'd4096);
        run_random(PHASE_ITEMS, 0);

        // Smallest legal frame
        wait_drained();
        apply_config(13'd2, 13'd2, 13'd0, 13'd0, 13'd1, 13'd1, 13'd2, 13'd2);
        run_random(PHASE_ITEMS, 0);

        // Single-column luma, empty chroma plane
        wait_drained();
        apply_config(13'd5, 13'd3, 13'd1, 13'd1, 13'd3, 13'd3, 13'd1, 13'd3);
        run_random(PHASE_ITEMS, 0);

        // All sizes zero: nothing in range, zero divisors
        wait_drained();
        apply_config(13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0);
        run_random(PHASE_ITEMS, 0);

        // Odd sizes downscaled, with a mid-phase pause until drained
        wait_drained();
        apply_config(13'd1919, 13'd1081, 13'd17, 13'd33, 13'd1279, 13'd719, 13'd853, 13'd481);
        run_random(PHASE_ITEMS, PHASE_ITEMS / 2);

        // Upscale a small window
        wait_drained();
        apply_config(13'd320, 13'd240, 13'd10, 13'd20, 13'd100, 13'd60, 13'd1920, 13'd1080);
        run_random(PHASE_ITEMS, 0);

        // Random geometries; some with raw register values, the last without idling
        for (int p = 0; p < 8; p++)
        begin
            wait_drained();
            if (p == 7)
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            else
            begin
                src_idle_pct  = $urandom_range(0, 40);
                sink_idle_pct = $urandom_range(0, 40);
            end
            if (p % 3 == 2)
            begin
                apply_config(SW'($urandom_range(0, 8191)), SW'($urandom_range(0, 8191)),
                             SW'($urandom_range(0, 8191)), SW'($urandom_range(0, 8191)),
                             SW'($urandom_range(0, 8191)), SW'($urandom_range(0, 8191)),
                             SW'($urandom_range(0, 8191)), SW'($urandom_range(0, 8191)));
            end
            else
            begin
                sw = SW'($urandom_range(2, 4096));
                sh = SW'($urandom_range(2, 4096));
                cw = SW'($urandom_range(1, sw));
                ch = SW'($urandom_range(1, sh));
                cx = SW'($urandom_range(0, sw - cw));
                cy = SW'($urandom_range(0, sh - ch));
                tw = SW'($urandom_range(2, 4096));
                th = SW'($urandom_range(2, 4096));
                apply_config(sw, sh, cx, cy, cw, ch, tw, th);
            end
            run_random(PHASE_ITEMS, 0);
        end

        wait_drained();
        if (offsets_sb.mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
